/* sv/oick_pkg.sv */
// oick_pkg: shared constants, types and the cosine table for the omni chassis kinematics
// no dependencies; used by every other file of the block
`default_nettype none

package oick_pkg;

    // cosine table geometry
    localparam int COS_TABLE_BITS = 8;
    localparam int TAB_N          = 1 << COS_TABLE_BITS;
    localparam int IDX_W          = COS_TABLE_BITS + 1;
    localparam int COS_W          = 15;
    localparam int PHASE_W        = 16;
    localparam int REM_W          = 14;

    // fixed angle offsets as binary angles
    localparam logic [PHASE_W-1:0] PHASE_225 = 16'd40960;
    localparam logic [PHASE_W-1:0] PHASE_135 = 16'd24576;

    // table build constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 10;
    localparam logic [63:0] TAYLOR_DIV [0:TAYLOR_TERMS-1] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    // datapath widths
    localparam int VEL_W       = 16;
    localparam int SPD_W       = 24;
    localparam int SCALE_W     = 16;
    localparam int PART_W      = 32;
    localparam int SUM_W       = 33;
    localparam int PROD_W      = SUM_W + SCALE_W + 1;
    localparam int W_SHIFT     = 15;
    localparam int FRAC_DROP   = 23;
    localparam int PIPE_DEPTH  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED  = 1'd1;
    localparam logic [SCALE_W-1:0]   WHEEL_SCALE_RST = 16'd256;

    // chassis modes
    typedef enum logic [1:0] {
        MODE_SAFE   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AUTO   = 2'd2
    } t_mode;

    // stage advance strobes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_adv;

    // side data carried alongside the arithmetic
    typedef struct packed {
        logic                    safe;
        logic signed [SPD_W-1:0] now_fl;
        logic signed [SPD_W-1:0] now_fr;
        logic signed [SPD_W-1:0] now_bl;
        logic signed [SPD_W-1:0] now_br;
    } t_side;

    typedef logic [COS_W-1:0] t_cos_tab [0:TAB_N];

    // quarter-wave cosine in q1.15 by a q30 taylor series, evaluated at elaboration
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab           tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        for (int k = 0; k <= TAB_N; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / TAB_N;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = $signed(term);
            for (int n = 0; n < TAYLOR_TERMS; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum + $signed(term);
                end else begin
                    sum = sum - $signed(term);
                end
            end
            if (sum <= 0) begin
                tab[k] = '0;
            end else begin
                r = ($unsigned(sum) + (64'd1 << 14)) >> 15;
                tab[k] = (r > 64'd32767) ? 15'h7fff : r[COS_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage

`default_nettype wire

/* sv/oick_cos_lut.sv */
// oick_cos_lut: binary angle to q1.15 cosine through the quarter-wave table
// depends on oick_pkg
`default_nettype none

module oick_cos_lut (
    input  wire logic [oick_pkg::PHASE_W-1:0] i_phase,
    output logic signed [oick_pkg::VEL_W-1:0] o_cos
);

    localparam int SH   = oick_pkg::REM_W - oick_pkg::COS_TABLE_BITS;
    localparam int HALF = (1 << SH) >> 1;

    logic [1:0]                      quad;
    logic [oick_pkg::REM_W-1:0]      rem;
    logic [oick_pkg::REM_W:0]        rem_rnd;
    logic [oick_pkg::IDX_W-1:0]      idx_raw;
    logic [oick_pkg::IDX_W-1:0]      idx;
    logic [oick_pkg::IDX_W-1:0]      idx_sel;
    logic [oick_pkg::COS_W-1:0]      mag;

    // quadrant split and rounding to the nearest table entry
    always_comb begin
        quad    = i_phase[oick_pkg::PHASE_W-1 -: 2];
        rem     = i_phase[oick_pkg::REM_W-1:0];
        rem_rnd = {1'b0, rem} + (oick_pkg::REM_W + 1)'(HALF);
        idx_raw = oick_pkg::IDX_W'(rem_rnd >> SH);
        idx     = (idx_raw > oick_pkg::IDX_W'(oick_pkg::TAB_N)) ?
                  oick_pkg::IDX_W'(oick_pkg::TAB_N) : idx_raw;
    end

    // odd quadrants read the mirrored entry, the middle two negate
    always_comb begin
        idx_sel = quad[0] ? (oick_pkg::IDX_W'(oick_pkg::TAB_N) - idx) : idx;
        mag     = oick_pkg::COS_TAB[idx_sel];
        if (quad[0] ^ quad[1]) begin
            o_cos = -$signed({1'b0, mag});
        end else begin
            o_cos = $signed({1'b0, mag});
        end
    end

endmodule

`default_nettype wire

/* sv/oick_mix.sv */
// oick_mix: stages two and three, the rotated velocity products and the wheel sums
// depends on oick_pkg
`default_nettype none

module oick_mix (
    input  wire logic                              i_clk,
    input  wire oick_pkg::t_adv                    i_adv,
    input  wire logic signed [oick_pkg::VEL_W-1:0] i_c1,
    input  wire logic signed [oick_pkg::VEL_W-1:0] i_c2,
    input  wire logic signed [oick_pkg::VEL_W-1:0] i_vx,
    input  wire logic signed [oick_pkg::VEL_W-1:0] i_vy,
    input  wire logic signed [oick_pkg::VEL_W-1:0] i_w,
    output logic signed [oick_pkg::SUM_W-1:0]      o_sum_fl,
    output logic signed [oick_pkg::SUM_W-1:0]      o_sum_fr,
    output logic signed [oick_pkg::SUM_W-1:0]      o_sum_bl,
    output logic signed [oick_pkg::SUM_W-1:0]      o_sum_br
);

    logic signed [oick_pkg::PART_W-1:0] r_vy_c1;
    logic signed [oick_pkg::PART_W-1:0] r_vx_c2;
    logic signed [oick_pkg::PART_W-1:0] r_vy_c2;
    logic signed [oick_pkg::PART_W-1:0] r_vx_c1;
    logic signed [oick_pkg::VEL_W-1:0]  r_w2;

    logic signed [oick_pkg::PART_W-1:0] n_a;
    logic signed [oick_pkg::PART_W-1:0] n_b;
    logic signed [oick_pkg::SUM_W-1:0]  n_ww;

    // stage two: four 16x16 products
    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_vy_c1 <= oick_pkg::PART_W'(i_vy) * oick_pkg::PART_W'(i_c1);
            r_vx_c2 <= oick_pkg::PART_W'(i_vx) * oick_pkg::PART_W'(i_c2);
            r_vy_c2 <= oick_pkg::PART_W'(i_vy) * oick_pkg::PART_W'(i_c2);
            r_vx_c1 <= oick_pkg::PART_W'(i_vx) * oick_pkg::PART_W'(i_c1);
            r_w2    <= i_w;
        end
    end

    // chassis-frame terms and the rotation term in q.15
    always_comb begin
        n_a  = r_vy_c1 + r_vx_c2;
        n_b  = r_vy_c2 - r_vx_c1;
        n_ww = oick_pkg::SUM_W'(r_w2) <<< oick_pkg::W_SHIFT;
    end

    // stage three: per-wheel sums
    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            o_sum_fl <= oick_pkg::SUM_W'(n_b) + n_ww;
            o_sum_fr <= n_ww - oick_pkg::SUM_W'(n_a);
            o_sum_bl <= oick_pkg::SUM_W'(n_a) + n_ww;
            o_sum_br <= n_ww - oick_pkg::SUM_W'(n_b);
        end
    end

endmodule

`default_nettype wire

/* sv/oick_scale.sv */
// oick_scale: stages four and five, wheel scale product, rounding, saturation, hold select
// depends on oick_pkg
`default_nettype none

module oick_scale (
    input  wire logic                                i_clk,
    input  wire oick_pkg::t_adv                      i_adv,
    input  wire logic [oick_pkg::SCALE_W-1:0]        i_wheel_scale,
    input  wire logic signed [oick_pkg::SUM_W-1:0]   i_sum_fl,
    input  wire logic signed [oick_pkg::SUM_W-1:0]   i_sum_fr,
    input  wire logic signed [oick_pkg::SUM_W-1:0]   i_sum_bl,
    input  wire logic signed [oick_pkg::SUM_W-1:0]   i_sum_br,
    input  wire oick_pkg::t_side                     i_side,
    output logic signed [oick_pkg::SPD_W-1:0]        o_target_fl,
    output logic signed [oick_pkg::SPD_W-1:0]        o_target_fr,
    output logic signed [oick_pkg::SPD_W-1:0]        o_target_bl,
    output logic signed [oick_pkg::SPD_W-1:0]        o_target_br,
    output logic                                     o_held
);

    localparam int RES_W = oick_pkg::PROD_W - oick_pkg::FRAC_DROP;
    localparam logic signed [oick_pkg::PROD_W-1:0] RND =
        oick_pkg::PROD_W'(1) << (oick_pkg::FRAC_DROP - 1);
    localparam logic signed [oick_pkg::SPD_W-1:0] SPD_MAX = {1'b0, {(oick_pkg::SPD_W-1){1'b1}}};
    localparam logic signed [oick_pkg::SPD_W-1:0] SPD_MIN = {1'b1, {(oick_pkg::SPD_W-1){1'b0}}};

    logic signed [oick_pkg::PROD_W-1:0] r_prod_fl;
    logic signed [oick_pkg::PROD_W-1:0] r_prod_fr;
    logic signed [oick_pkg::PROD_W-1:0] r_prod_bl;
    logic signed [oick_pkg::PROD_W-1:0] r_prod_br;
    logic signed [oick_pkg::SCALE_W:0]  k_s;

    // round half up to q15.8, then clip to 24 bits
    function automatic logic signed [oick_pkg::SPD_W-1:0] round_sat(
        input logic signed [oick_pkg::PROD_W-1:0] prod
    );
        logic signed [oick_pkg::PROD_W-1:0] t;
        logic signed [RES_W-1:0]            r;
        logic [RES_W-oick_pkg::SPD_W:0]     top;
        t   = prod + RND;
        r   = t[oick_pkg::PROD_W-1:oick_pkg::FRAC_DROP];
        top = r[RES_W-1:oick_pkg::SPD_W-1];
        if ((&top) || !(|top)) begin
            return r[oick_pkg::SPD_W-1:0];
        end else begin
            return r[RES_W-1] ? SPD_MIN : SPD_MAX;
        end
    endfunction

    assign k_s = $signed({1'b0, i_wheel_scale});

    // stage four: scale each wheel sum
    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_prod_fl <= oick_pkg::PROD_W'(i_sum_fl) * oick_pkg::PROD_W'(k_s);
            r_prod_fr <= oick_pkg::PROD_W'(i_sum_fr) * oick_pkg::PROD_W'(k_s);
            r_prod_bl <= oick_pkg::PROD_W'(i_sum_bl) * oick_pkg::PROD_W'(k_s);
            r_prod_br <= oick_pkg::PROD_W'(i_sum_br) * oick_pkg::PROD_W'(k_s);
        end
    end

    // stage five: output register, safe mode passes the current speeds
    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            if (i_side.safe) begin
                o_target_fl <= i_side.now_fl;
                o_target_fr <= i_side.now_fr;
                o_target_bl <= i_side.now_bl;
                o_target_br <= i_side.now_br;
            end else begin
                o_target_fl <= round_sat(r_prod_fl);
                o_target_fr <= round_sat(r_prod_fr);
                o_target_bl <= round_sat(r_prod_bl);
                o_target_br <= round_sat(r_prod_br);
            end
            o_held <= i_side.safe;
        end
    end

endmodule

`default_nettype wire

/* sv/omni_chassis_inverse_kinematics_unit.sv */
// omni_chassis_inverse_kinematics_unit: top level, stage one, pipeline control, registers
// depends on oick_pkg, oick_cos_lut, oick_mix, oick_scale
//
// Usage: one command item per cycle on the input channel (i_valid / o_stall), while
// o_stall is low, carries mode, spin request, world velocity, rotation rate, chassis
// angle and the four current wheel speeds. One result item per command leaves on the
// output channel (o_valid / i_stall) with four wheel targets and the held flag.
// Throughput is one item per cycle while i_stall is low, set by a five-stage pipeline
// (table lookup, products, sums, scale multiply, round and saturate). Bubbles close up
// while the receiver stalls; o_stall rises only when every stage holds an item and
// i_stall is high.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) take effect at once:
// index 0 wheel scale, index 1 spin speed. The user must make them only while no item
// is in flight; the block itself does not enforce this.
// Reset (synchronous, active low) empties the pipeline and restores wheel scale 256
// and spin speed 0.
`default_nettype none

module omni_chassis_inverse_kinematics_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // command channel
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic [1:0]                             i_mode,
    input  wire logic                                   i_spin_request,
    input  wire logic signed [oick_pkg::VEL_W-1:0]      i_world_vx,
    input  wire logic signed [oick_pkg::VEL_W-1:0]      i_world_vy,
    input  wire logic signed [oick_pkg::VEL_W-1:0]      i_rotation_rate,
    input  wire logic [oick_pkg::PHASE_W-1:0]           i_chassis_angle,
    input  wire logic signed [oick_pkg::SPD_W-1:0]      i_now_fll,
    input  wire logic signed [oick_pkg::SPD_W-1:0]      i_now_frl,
    input  wire logic signed [oick_pkg::SPD_W-1:0]      i_now_bll,
    input  wire logic signed [oick_pkg::SPD_W-1:0]      i_now_brl,
    // result channel
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [oick_pkg::SPD_W-1:0]           o_target_fll,
    output logic signed [oick_pkg::SPD_W-1:0]           o_target_frl,
    output logic signed [oick_pkg::SPD_W-1:0]           o_target_bll,
    output logic signed [oick_pkg::SPD_W-1:0]           o_target_brl,
    output logic                                        o_held,
    // configuration channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [oick_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [oick_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [oick_pkg::PIPE_DEPTH:1]      r_valid;
    oick_pkg::t_adv                     adv;

    logic [oick_pkg::SCALE_W-1:0]       r_wheel_scale;
    logic signed [oick_pkg::VEL_W-1:0]  r_spin_speed;

    logic [oick_pkg::PHASE_W-1:0]       n_phase1;
    logic [oick_pkg::PHASE_W-1:0]       n_phase2;
    logic signed [oick_pkg::VEL_W-1:0]  n_c1;
    logic signed [oick_pkg::VEL_W-1:0]  n_c2;
    logic signed [oick_pkg::VEL_W-1:0]  n_w;
    oick_pkg::t_side                    n_side;

    logic signed [oick_pkg::VEL_W-1:0]  r_c1;
    logic signed [oick_pkg::VEL_W-1:0]  r_c2;
    logic signed [oick_pkg::VEL_W-1:0]  r_vx;
    logic signed [oick_pkg::VEL_W-1:0]  r_vy;
    logic signed [oick_pkg::VEL_W-1:0]  r_w;
    oick_pkg::t_side                    r_side1;
    oick_pkg::t_side                    r_side2;
    oick_pkg::t_side                    r_side3;
    oick_pkg::t_side                    r_side4;

    logic signed [oick_pkg::SUM_W-1:0]  sum_fl;
    logic signed [oick_pkg::SUM_W-1:0]  sum_fr;
    logic signed [oick_pkg::SUM_W-1:0]  sum_bl;
    logic signed [oick_pkg::SUM_W-1:0]  sum_br;

    // per-stage advance: a stage loads when empty or when the next one moves on
    always_comb begin
        adv.s5  = !r_valid[5] || !i_stall;
        adv.s4  = !r_valid[4] || adv.s5;
        adv.s3  = !r_valid[3] || adv.s4;
        adv.s2  = !r_valid[2] || adv.s3;
        adv.s1  = !r_valid[1] || adv.s2;
        o_stall = !adv.s1;
        o_valid = r_valid[5];
    end

    // valid bits travel with the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv.s1) r_valid[1] <= i_valid;
            if (adv.s2) r_valid[2] <= r_valid[1];
            if (adv.s3) r_valid[3] <= r_valid[2];
            if (adv.s4) r_valid[4] <= r_valid[3];
            if (adv.s5) r_valid[5] <= r_valid[4];
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_scale <= oick_pkg::WHEEL_SCALE_RST;
            r_spin_speed  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                oick_pkg::CFG_WHEEL_SCALE: r_wheel_scale <= i_cfg_data;
                oick_pkg::CFG_SPIN_SPEED:  r_spin_speed  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // stage one: angle offsets, cosine lookups, rotation rate select
    always_comb begin
        n_phase1 = oick_pkg::PHASE_225 - i_chassis_angle;
        n_phase2 = i_chassis_angle - oick_pkg::PHASE_135;
        if (i_mode == oick_pkg::MODE_AUTO) begin
            n_w = i_spin_request ? r_spin_speed : '0;
        end else begin
            n_w = i_rotation_rate;
        end
        n_side.safe   = (i_mode == oick_pkg::MODE_SAFE);
        n_side.now_fl = i_now_fll;
        n_side.now_fr = i_now_frl;
        n_side.now_bl = i_now_bll;
        n_side.now_br = i_now_brl;
    end

    oick_cos_lut u_cos1 (
        .i_phase (n_phase1),
        .o_cos   (n_c1)
    );

    oick_cos_lut u_cos2 (
        .i_phase (n_phase2),
        .o_cos   (n_c2)
    );

    always_ff @(posedge i_clk) begin
        if (adv.s1) begin
            r_c1    <= n_c1;
            r_c2    <= n_c2;
            r_vx    <= i_world_vx;
            r_vy    <= i_world_vy;
            r_w     <= n_w;
            r_side1 <= n_side;
        end
    end

    // side data follows the item to the output stage
    always_ff @(posedge i_clk) begin
        if (adv.s2) r_side2 <= r_side1;
        if (adv.s3) r_side3 <= r_side2;
        if (adv.s4) r_side4 <= r_side3;
    end

    oick_mix u_mix (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_c1     (r_c1),
        .i_c2     (r_c2),
        .i_vx     (r_vx),
        .i_vy     (r_vy),
        .i_w      (r_w),
        .o_sum_fl (sum_fl),
        .o_sum_fr (sum_fr),
        .o_sum_bl (sum_bl),
        .o_sum_br (sum_br)
    );

    oick_scale u_scale (
        .i_clk         (i_clk),
        .i_adv         (adv),
        .i_wheel_scale (r_wheel_scale),
        .i_sum_fl      (sum_fl),
        .i_sum_fr      (sum_fr),
        .i_sum_bl      (sum_bl),
        .i_sum_br      (sum_br),
        .i_side        (r_side4),
        .o_target_fl   (o_target_fll),
        .o_target_fr   (o_target_frl),
        .o_target_bl   (o_target_bll),
        .o_target_br   (o_target_brl),
        .o_held        (o_held)
    );

endmodule

`default_nettype wire

/* sv/oick_checker.sv */
// oick_checker: port-level assertions for the omni chassis kinematics top level
// depends on oick_pkg; attached to the top level by the bind at the end of this file
`default_nettype none

module oick_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_valid,
    input wire logic                                   o_stall,
    input wire logic [1:0]                             i_mode,
    input wire logic signed [oick_pkg::SPD_W-1:0]      i_now_fll,
    input wire logic signed [oick_pkg::SPD_W-1:0]      i_now_brl,
    input wire logic                                   o_valid,
    input wire logic                                   i_stall,
    input wire logic signed [oick_pkg::SPD_W-1:0]      o_target_fll,
    input wire logic signed [oick_pkg::SPD_W-1:0]      o_target_brl,
    input wire logic                                   o_held
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // upstream is only held off when a result is waiting at the output and the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted item reaches the output when the output does not stall in between
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid)
        else $error("item did not arrive after five free cycles");

    // a safe-mode item comes back held with its front-left and back-right current speeds
    a_safe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_mode == oick_pkg::MODE_SAFE)
        ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> (o_held && o_target_fll == $past(i_now_fll, 5)
             && o_target_brl == $past(i_now_brl, 5)))
        else $error("safe mode item not passed through");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_target_fll) && $stable(o_held)))
        else $error("stalled result changed");

endmodule

bind omni_chassis_inverse_kinematics_unit oick_checker u_oick_checker (.*);

`default_nettype wire
